### rtl/i2cm_pkg.sv
package i2cm_pkg;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned TICKS_W    = 16;

    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    // Register index as selected by paddr[2].
    localparam logic REG_LOW_TICKS  = 1'b0;
    localparam logic REG_HIGH_TICKS = 1'b1;

    localparam logic [TICKS_W-1:0] LOW_TICKS_RST  = 16'd250;
    localparam logic [TICKS_W-1:0] HIGH_TICKS_RST = 16'd250;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic [3:0] BIT_CNT_DONE  = 4'd9;
    localparam logic [7:0] SHIFT_RST     = 8'hFF;

    typedef enum logic [9:0] {
        PH_IDLE       = 10'b0000000001,
        PH_START_WAIT = 10'b0000000010,
        PH_START_HOLD = 10'b0000000100,
        PH_STOP_WAIT  = 10'b0000001000,
        PH_STOP_HOLD1 = 10'b0000010000,
        PH_STOP_HOLD2 = 10'b0000100000,
        PH_BIT_LOW    = 10'b0001000000,
        PH_BIT_WAIT   = 10'b0010000000,
        PH_BIT_HIGH   = 10'b0100000000,
        PH_TAIL_LOW   = 10'b1000000000
    } t_phase;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

endpackage

### rtl/i2c_master_byte_engine.sv
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_cmd, i_data, i_send_ack, i_scl_in, i_sda_in
// result    out        o_out_valid / i_out_ready  o_scl_pull_low .. o_rejected
// config    in         APB (psel, penable, ...)   low_ticks, high_ticks
//
// Every item, command or tick, updates the bus state registers and the result
// register at the edge where the item is accepted.
// One new item is accepted each cycle as long as the result register is empty
// or is being drained in the same cycle; a stalled result stalls the input.
// Reset is synchronous and active low; it returns the engine to idle with both
// lines released and both timing registers at 250 ticks.
module i2c_master_byte_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_cmd,
    input  logic [7:0]  i_data,
    input  logic        i_send_ack,
    input  logic        i_scl_in,
    input  logic        i_sda_in,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_scl_pull_low,
    output logic        o_sda_pull_low,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [7:0]  o_read_byte,
    output logic        o_nack,
    output logic        o_rejected,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [i2cm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import i2cm_pkg::*;

    logic [TICKS_W-1:0] r_low_ticks;
    logic [TICKS_W-1:0] r_high_ticks;

    t_phase             r_phase, n_phase;
    t_op                r_op, n_op;
    logic [TICKS_W-1:0] r_timer, n_timer;
    logic [3:0]         r_bit_cnt, n_bit_cnt;
    logic [7:0]         r_shift, n_shift;
    logic               r_ack_to_send, n_ack_to_send;
    logic               r_nack_seen, n_nack_seen;
    logic               r_scl_drive, n_scl_drive;
    logic               r_sda_drive, n_sda_drive;

    logic               r_out_valid;
    logic               r_busy, r_done, r_nack, r_rejected;
    logic [7:0]         r_read_byte;
    logic               n_done, n_nack, n_rejected;
    logic [7:0]         n_read_byte;

    logic               in_accept;
    logic               cfg_write;
    logic               is_cmd;
    logic [TICKS_W-1:0] timer_inc;
    logic               low_elapsed;
    logic               high_elapsed;
    logic [3:0]         bit_cnt_inc;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = {16'd0, (paddr[2] == REG_HIGH_TICKS) ? r_high_ticks : r_low_ticks};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_ticks  <= LOW_TICKS_RST;
            r_high_ticks <= HIGH_TICKS_RST;
        end else if (cfg_write) begin
            if (paddr[2] == REG_HIGH_TICKS) begin
                r_high_ticks <= pwdata[TICKS_W-1:0];
            end else begin
                r_low_ticks <= pwdata[TICKS_W-1:0];
            end
        end
    end

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;
    assign is_cmd     = (i_cmd == CMD_START) || (i_cmd == CMD_STOP) ||
                        (i_cmd == CMD_WRITE) || (i_cmd == CMD_READ);

    // A limit of zero compares as always elapsed, the same as a limit of one.
    assign timer_inc    = r_timer + 16'd1;
    assign low_elapsed  = timer_inc >= r_low_ticks;
    assign high_elapsed = timer_inc >= r_high_ticks;
    assign bit_cnt_inc  = r_bit_cnt + 4'd1;

    always_comb begin
        n_phase       = r_phase;
        n_op          = r_op;
        n_timer       = r_timer;
        n_bit_cnt     = r_bit_cnt;
        n_shift       = r_shift;
        n_ack_to_send = r_ack_to_send;
        n_nack_seen   = r_nack_seen;
        n_scl_drive   = r_scl_drive;
        n_sda_drive   = r_sda_drive;
        n_done        = 1'b0;
        n_read_byte   = 8'd0;
        n_nack        = 1'b0;
        n_rejected    = 1'b0;

        if (is_cmd && (r_phase != PH_IDLE)) begin
            n_rejected = 1'b1;
        end else if (is_cmd) begin
            n_timer   = '0;
            n_bit_cnt = '0;
            unique case (i_cmd)
                CMD_START: begin
                    n_op        = OP_START;
                    n_scl_drive = 1'b0;
                    n_sda_drive = 1'b0;
                    n_phase     = PH_START_WAIT;
                end
                CMD_STOP: begin
                    n_op        = OP_STOP;
                    n_scl_drive = 1'b0;
                    n_sda_drive = 1'b1;
                    n_phase     = PH_STOP_WAIT;
                end
                CMD_WRITE: begin
                    n_op        = OP_WRITE;
                    n_shift     = i_data;
                    n_nack_seen = 1'b0;
                    n_scl_drive = 1'b1;
                    n_sda_drive = !i_data[7];
                    n_phase     = PH_BIT_LOW;
                end
                default: begin
                    n_op          = OP_READ;
                    n_shift       = SHIFT_RST;
                    n_ack_to_send = i_send_ack;
                    n_scl_drive   = 1'b1;
                    n_sda_drive   = 1'b0;
                    n_phase       = PH_BIT_LOW;
                end
            endcase
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    n_phase = PH_IDLE;
                end
                PH_START_WAIT: begin
                    if (i_scl_in) begin
                        n_sda_drive = 1'b1;
                        n_timer     = '0;
                        n_phase     = PH_START_HOLD;
                    end
                end
                PH_START_HOLD: begin
                    n_timer = low_elapsed ? '0 : timer_inc;
                    if (low_elapsed) begin
                        n_scl_drive = 1'b1;
                        n_sda_drive = 1'b0;
                        n_phase     = PH_IDLE;
                        n_done      = 1'b1;
                    end
                end
                PH_STOP_WAIT: begin
                    if (i_scl_in) begin
                        n_timer = '0;
                        n_phase = PH_STOP_HOLD1;
                    end
                end
                PH_STOP_HOLD1: begin
                    n_timer = high_elapsed ? '0 : timer_inc;
                    if (high_elapsed) begin
                        n_sda_drive = 1'b0;
                        n_phase     = PH_STOP_HOLD2;
                    end
                end
                PH_STOP_HOLD2: begin
                    n_timer = high_elapsed ? '0 : timer_inc;
                    if (high_elapsed) begin
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end
                end
                PH_BIT_LOW: begin
                    n_timer = low_elapsed ? '0 : timer_inc;
                    if (low_elapsed) begin
                        n_scl_drive = 1'b0;
                        n_phase     = PH_BIT_WAIT;
                    end
                end
                PH_BIT_WAIT: begin
                    if (i_scl_in) begin
                        n_timer = '0;
                        n_phase = PH_BIT_HIGH;
                    end
                end
                PH_BIT_HIGH: begin
                    n_timer = high_elapsed ? '0 : timer_inc;
                    if (high_elapsed) begin
                        n_scl_drive = 1'b1;
                        if (r_bit_cnt < BITS_PER_BYTE) begin
                            n_shift   = {r_shift[6:0], i_sda_in};
                            n_bit_cnt = bit_cnt_inc;
                            // The next data bit sits in bit 6 before the shift.
                            if ((r_op == OP_WRITE) && (bit_cnt_inc < BITS_PER_BYTE)) begin
                                n_sda_drive = !r_shift[6];
                            end else begin
                                n_sda_drive = 1'b0;
                            end
                            n_phase = (bit_cnt_inc >= BITS_PER_BYTE) ? PH_TAIL_LOW
                                                                     : PH_BIT_LOW;
                        end else begin
                            if (r_op == OP_WRITE) begin
                                n_nack_seen = i_sda_in;
                            end
                            n_bit_cnt   = BIT_CNT_DONE;
                            n_sda_drive = 1'b0;
                            n_phase     = PH_TAIL_LOW;
                        end
                    end
                end
                PH_TAIL_LOW: begin
                    n_timer = low_elapsed ? '0 : timer_inc;
                    if (low_elapsed) begin
                        if (r_bit_cnt == BITS_PER_BYTE) begin
                            // Data byte finished: the acknowledge bit follows.
                            if (r_op == OP_WRITE) begin
                                n_shift     = SHIFT_RST;
                                n_sda_drive = 1'b0;
                            end else begin
                                n_sda_drive = r_ack_to_send;
                            end
                            n_phase = PH_BIT_LOW;
                        end else begin
                            n_done = 1'b1;
                            if (r_op == OP_READ) begin
                                n_read_byte = r_shift;
                            end else begin
                                n_nack = r_nack_seen;
                            end
                            n_shift     = SHIFT_RST;
                            n_sda_drive = 1'b0;
                            n_phase     = PH_IDLE;
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_op          <= OP_START;
            r_timer       <= '0;
            r_bit_cnt     <= '0;
            r_shift       <= SHIFT_RST;
            r_ack_to_send <= 1'b0;
            r_nack_seen   <= 1'b0;
            r_scl_drive   <= 1'b0;
            r_sda_drive   <= 1'b0;
        end else if (in_accept) begin
            r_phase       <= n_phase;
            r_op          <= n_op;
            r_timer       <= n_timer;
            r_bit_cnt     <= n_bit_cnt;
            r_shift       <= n_shift;
            r_ack_to_send <= n_ack_to_send;
            r_nack_seen   <= n_nack_seen;
            r_scl_drive   <= n_scl_drive;
            r_sda_drive   <= n_sda_drive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload: the drive levels are the state just written.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_busy      <= (n_phase != PH_IDLE);
            r_done      <= n_done;
            r_read_byte <= n_read_byte;
            r_nack      <= n_nack;
            r_rejected  <= n_rejected;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_scl_pull_low = r_scl_drive;
    assign o_sda_pull_low = r_sda_drive;
    assign o_busy_res     = r_busy;
    assign o_done_res     = r_done;
    assign o_read_byte    = r_read_byte;
    assign o_nack         = r_nack;
    assign o_rejected     = r_rejected;

`ifndef NO_ASSERTIONS
    a_done_not_rejected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_done && r_rejected))
        else $error("done and rejected reported on the same transaction");

    a_done_means_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_done) |-> !r_busy)
        else $error("operation finished but engine still busy");

    a_data_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_done) |-> ((r_read_byte == 8'd0) && !r_nack))
        else $error("read byte or nack reported without completion");

    a_bit_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_cnt <= BIT_CNT_DONE)
        else $error("bit counter out of range");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !in_accept)
        else $error("input accepted while a stalled result is pending");

    a_drive_reg_tracks_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_busy == (r_phase != PH_IDLE)))
        else $error("busy flag disagrees with phase register");
`endif

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import i2cm_pkg::*;

    typedef struct packed {
        logic       scl_pull_low;
        logic       sda_pull_low;
        logic       busy;
        logic       done;
        logic [7:0] read_byte;
        logic       nack;
        logic       rejected;
    } t_bus_result;

    localparam int SDA_LOW  = 0;
    localparam int SDA_HIGH = 1;
    localparam int SDA_RAND = 2;

    localparam logic [CFG_ADDR_W-1:0] ADDR_LOW_TICKS  = {REG_LOW_TICKS, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] ADDR_HIGH_TICKS = {REG_HIGH_TICKS, 2'b00};

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_cmd      = CMD_TICK;
    logic [7:0]  i_data     = 8'h00;
    logic        i_send_ack = 1'b0;
    logic        i_scl_in   = 1'b1;
    logic        i_sda_in   = 1'b1;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_scl_pull_low;
    logic        o_sda_pull_low;
    logic        o_busy_res;
    logic        o_done_res;
    logic [7:0]  o_read_byte;
    logic        o_nack;
    logic        o_rejected;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [31:0]           pwdata  = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // Predicted bus engine state and timing registers.
    t_phase             bus_phase;
    t_op                bus_op;
    logic [TICKS_W-1:0] phase_cnt;
    logic [3:0]         bits_done;
    logic [7:0]         shifter;
    logic               ack_level;
    logic               nack_level;
    logic               scl_low;
    logic               sda_low;
    logic [TICKS_W-1:0] cfg_low_ticks;
    logic [TICKS_W-1:0] cfg_high_ticks;

    t_bus_result expected_results[$];
    int unsigned mismatch_count = 0;
    int unsigned items_sent     = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned stretch_pct    = 0;
    int unsigned noise_pct      = 0;

    i2c_master_byte_engine u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_data         (i_data),
        .i_send_ack     (i_send_ack),
        .i_scl_in       (i_scl_in),
        .i_sda_in       (i_sda_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_scl_pull_low (o_scl_pull_low),
        .o_sda_pull_low (o_sda_pull_low),
        .o_busy_res     (o_busy_res),
        .o_done_res     (o_done_res),
        .o_read_byte    (o_read_byte),
        .o_nack         (o_nack),
        .o_rejected     (o_rejected),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #100_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    task automatic reset_bus_model();
        bus_phase      = PH_IDLE;
        bus_op         = OP_START;
        phase_cnt      = '0;
        bits_done      = '0;
        shifter        = SHIFT_RST;
        ack_level      = 1'b0;
        nack_level     = 1'b0;
        scl_low        = 1'b0;
        sda_low        = 1'b0;
        cfg_low_ticks  = LOW_TICKS_RST;
        cfg_high_ticks = HIGH_TICKS_RST;
    endtask

    // A limit of zero ends the phase on the first tick, same as one.
    function automatic logic phase_over(input logic [TICKS_W-1:0] limit);
        phase_cnt = phase_cnt + 16'd1;
        if (phase_cnt >= limit) begin
            phase_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic predict_bus_item(input logic [2:0] cmd, input logic [7:0] data,
                                    input logic ack, input logic scl, input logic sda,
                                    output t_bus_result res);
        logic is_cmd;
        res    = '0;
        is_cmd = (cmd >= CMD_START) && (cmd <= CMD_READ);
        if (is_cmd && bus_phase != PH_IDLE) begin
            res.rejected = 1'b1;
        end else if (is_cmd) begin
            phase_cnt = '0;
            bits_done = '0;
            case (cmd)
                CMD_START: begin
                    bus_op    = OP_START;
                    scl_low   = 1'b0;
                    sda_low   = 1'b0;
                    bus_phase = PH_START_WAIT;
                end
                CMD_STOP: begin
                    bus_op    = OP_STOP;
                    scl_low   = 1'b0;
                    sda_low   = 1'b1;
                    bus_phase = PH_STOP_WAIT;
                end
                CMD_WRITE: begin
                    bus_op     = OP_WRITE;
                    shifter    = data;
                    nack_level = 1'b0;
                    scl_low    = 1'b1;
                    sda_low    = ~data[7];
                    bus_phase  = PH_BIT_LOW;
                end
                default: begin
                    bus_op    = OP_READ;
                    shifter   = SHIFT_RST;
                    ack_level = ack;
                    scl_low   = 1'b1;
                    sda_low   = 1'b0;
                    bus_phase = PH_BIT_LOW;
                end
            endcase
        end else begin
            case (bus_phase)
                PH_START_WAIT: if (scl) begin
                    sda_low   = 1'b1;
                    phase_cnt = '0;
                    bus_phase = PH_START_HOLD;
                end
                PH_START_HOLD: if (phase_over(cfg_low_ticks)) begin
                    scl_low   = 1'b1;
                    sda_low   = 1'b0;
                    bus_phase = PH_IDLE;
                    res.done  = 1'b1;
                end
                PH_STOP_WAIT: if (scl) begin
                    phase_cnt = '0;
                    bus_phase = PH_STOP_HOLD1;
                end
                PH_STOP_HOLD1: if (phase_over(cfg_high_ticks)) begin
                    sda_low   = 1'b0;
                    bus_phase = PH_STOP_HOLD2;
                end
                PH_STOP_HOLD2: if (phase_over(cfg_high_ticks)) begin
                    bus_phase = PH_IDLE;
                    res.done  = 1'b1;
                end
                PH_BIT_LOW: if (phase_over(cfg_low_ticks)) begin
                    scl_low   = 1'b0;
                    bus_phase = PH_BIT_WAIT;
                end
                PH_BIT_WAIT: if (scl) begin
                    phase_cnt = '0;
                    bus_phase = PH_BIT_HIGH;
                end
                PH_BIT_HIGH: if (phase_over(cfg_high_ticks)) begin
                    scl_low = 1'b1;
                    if (bits_done < BITS_PER_BYTE) begin
                        shifter   = {shifter[6:0], sda};
                        bits_done = bits_done + 4'd1;
                        if (bus_op == OP_WRITE && bits_done < BITS_PER_BYTE) begin
                            sda_low = ~shifter[7];
                        end else begin
                            sda_low = 1'b0;
                        end
                    end else begin
                        // End of the acknowledge bit.
                        if (bus_op == OP_WRITE) begin
                            nack_level = sda;
                        end
                        bits_done = BIT_CNT_DONE;
                        sda_low   = 1'b0;
                    end
                    bus_phase = (bits_done >= BITS_PER_BYTE) ? PH_TAIL_LOW : PH_BIT_LOW;
                end
                PH_TAIL_LOW: if (phase_over(cfg_low_ticks)) begin
                    if (bits_done == BITS_PER_BYTE) begin
                        if (bus_op == OP_WRITE) begin
                            shifter = SHIFT_RST;
                            sda_low = 1'b0;
                        end else begin
                            sda_low = ack_level;
                        end
                        bus_phase = PH_BIT_LOW;
                    end else begin
                        res.done = 1'b1;
                        if (bus_op == OP_READ) begin
                            res.read_byte = shifter;
                        end else begin
                            res.nack = nack_level;
                        end
                        shifter   = SHIFT_RST;
                        sda_low   = 1'b0;
                        bus_phase = PH_IDLE;
                    end
                end
                default: bus_phase = PH_IDLE;
            endcase
        end
        res.scl_pull_low = scl_low;
        res.sda_pull_low = sda_low;
        res.busy         = (bus_phase != PH_IDLE);
    endtask

    task automatic send_item(input logic [2:0] cmd, input logic [7:0] data,
                             input logic ack, input logic scl, input logic sda);
        t_bus_result res;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_data     <= data;
        i_send_ack <= ack;
        i_scl_in   <= scl;
        i_sda_in   <= sda;
        do @(posedge i_clk); while (!o_in_ready);
        predict_bus_item(cmd, data, ack, scl, sda, res);
        expected_results.push_back(res);
        items_sent++;
    endtask

    task automatic send_tick(input int sda_mode);
        logic [2:0] cmd;
        logic       sda;
        cmd = CMD_TICK;
        if ($urandom_range(99) < noise_pct) begin
            cmd = 3'($urandom_range(7, 1));
        end
        if (sda_mode == SDA_RAND) begin
            sda = 1'($urandom_range(1));
        end else begin
            sda = (sda_mode == SDA_HIGH);
        end
        send_item(cmd, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  $urandom_range(99) >= stretch_pct, sda);
    endtask

    // Issue one command and keep ticking the bus until it completes.
    task automatic run_op(input logic [2:0] cmd, input logic [7:0] data,
                          input logic ack, input int sda_mode);
        send_item(cmd, data, ack, 1'($urandom_range(1)), 1'($urandom_range(1)));
        while (bus_phase != PH_IDLE) begin
            send_tick(sda_mode);
        end
    endtask

    task automatic apb_access(input logic is_write, input logic [CFG_ADDR_W-1:0] addr,
                              input logic [31:0] value, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Timing registers are only touched once every transaction has drained.
    task automatic set_timing(input logic [TICKS_W-1:0] low, input logic [TICKS_W-1:0] high);
        logic [31:0] rdata;
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        apb_access(1'b1, ADDR_LOW_TICKS, {16'd0, low}, rdata);
        apb_access(1'b1, ADDR_HIGH_TICKS, {16'd0, high}, rdata);
        cfg_low_ticks  = low;
        cfg_high_ticks = high;
        apb_access(1'b0, ADDR_LOW_TICKS, '0, rdata);
        if (rdata[TICKS_W-1:0] !== low) begin
            note_failure($sformatf("low_ticks read %h, expected %h", rdata, low));
        end
        apb_access(1'b0, ADDR_HIGH_TICKS, '0, rdata);
        if (rdata[TICKS_W-1:0] !== high) begin
            note_failure($sformatf("high_ticks read %h, expected %h", rdata, high));
        end
    endtask

    task automatic test_directed_ops();
        set_timing(16'd1, 16'd1);
        stretch_pct = 30;
        run_op(CMD_START, 8'h00, 1'b0, SDA_RAND);
        run_op(CMD_WRITE, 8'h00, 1'b0, SDA_LOW);
        run_op(CMD_WRITE, 8'hFF, 1'b1, SDA_HIGH);
        run_op(CMD_WRITE, 8'h5A, 1'b0, SDA_RAND);
        run_op(CMD_READ, 8'h00, 1'b1, SDA_HIGH);
        run_op(CMD_READ, 8'hFF, 1'b0, SDA_LOW);
        run_op(CMD_READ, 8'h3C, 1'b1, SDA_RAND);
        run_op(CMD_STOP, 8'h00, 1'b0, SDA_RAND);
        set_timing(16'd2, 16'd3);
        run_op(CMD_WRITE, 8'hA5, 1'b1, SDA_RAND);
        run_op(CMD_READ, 8'h00, 1'b0, SDA_RAND);
    endtask

    task automatic test_busy_and_unused();
        logic [2:0] code;
        stretch_pct = 10;
        // Unused codes while idle behave as ticks.
        for (code = 3'd5; code != 3'd0; code++) begin
            send_item(code, 8'($urandom_range(255)), 1'b1, 1'b1, 1'b0);
        end
        send_item(CMD_TICK, 8'hFF, 1'b1, 1'b0, 1'b1);
        send_item(CMD_START, 8'h00, 1'b0, 1'b0, 1'b0);
        for (code = CMD_START; code <= CMD_READ; code++) begin
            send_item(code, 8'hC3, 1'b1, 1'b1, 1'b1);
        end
        while (bus_phase != PH_IDLE) send_tick(SDA_RAND);
        noise_pct = 30;
        run_op(CMD_WRITE, 8'h96, 1'b0, SDA_RAND);
        run_op(CMD_READ, 8'h00, 1'b1, SDA_RAND);
        noise_pct = 0;
    endtask

    task automatic test_zero_ticks();
        set_timing(16'd0, 16'd0);
        run_op(CMD_START, 8'h00, 1'b0, SDA_RAND);
        run_op(CMD_WRITE, 8'($urandom_range(255)), 1'b0, SDA_RAND);
        run_op(CMD_READ, 8'h00, 1'b0, SDA_RAND);
        run_op(CMD_STOP, 8'h00, 1'b0, SDA_RAND);
    endtask

    // The largest limits are entered and then cut short, so a phase that
    // has already run past the new limit ends on the following tick.
    task automatic test_extreme_ticks();
        stretch_pct = 0;
        set_timing(16'hFFFF, 16'd1);
        send_item(CMD_START, 8'h00, 1'b0, 1'b1, 1'b1);
        repeat (40) send_tick(SDA_RAND);
        set_timing(16'd2, 16'd1);
        while (bus_phase != PH_IDLE) send_tick(SDA_RAND);
        set_timing(16'd1, 16'hFFFF);
        send_item(CMD_STOP, 8'h00, 1'b0, 1'b1, 1'b1);
        repeat (40) send_tick(SDA_RAND);
        set_timing(16'd1, 16'd3);
        while (bus_phase != PH_IDLE) send_tick(SDA_RAND);
    endtask

    function automatic logic [TICKS_W-1:0] pick_ticks();
        if ($urandom_range(7) == 0) begin
            return TICKS_W'($urandom_range(12, 1));
        end
        return TICKS_W'($urandom_range(3, 1));
    endfunction

    task automatic test_random_traffic();
        int unsigned target;
        int unsigned pick;
        for (int ph = 0; ph < 4; ph++) begin
            set_timing(pick_ticks(), pick_ticks());
            send_idle_pct  = (ph == 1) ? 83 : (ph == 3) ? 17 : 0;
            recv_stall_pct = (ph == 2) ? 83 : (ph == 3) ? 17 : 0;
            stretch_pct    = 20;
            noise_pct      = 4;
            target         = items_sent + 200;
            while (items_sent < target) begin
                pick = $urandom_range(99);
                if (pick < 20) begin
                    run_op(CMD_START, 8'($urandom_range(255)), 1'($urandom_range(1)),
                           SDA_RAND);
                end else if (pick < 35) begin
                    run_op(CMD_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)),
                           SDA_RAND);
                end else if (pick < 62) begin
                    run_op(CMD_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                           SDA_RAND);
                end else if (pick < 89) begin
                    run_op(CMD_READ, 8'($urandom_range(255)), 1'($urandom_range(1)),
                           SDA_RAND);
                end else begin
                    // Idle noise: a tick or an unused code.
                    send_item(($urandom_range(1) == 0) ? CMD_TICK : 3'($urandom_range(7, 5)),
                              8'($urandom_range(255)), 1'($urandom_range(1)),
                              1'($urandom_range(1)), 1'($urandom_range(1)));
                end
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    always @(posedge i_clk) begin : result_check
        t_bus_result got;
        t_bus_result want;
        got = {o_scl_pull_low, o_sda_pull_low, o_busy_res, o_done_res,
               o_read_byte, o_nack, o_rejected};
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                note_failure("result transaction with nothing expected");
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    note_failure($sformatf({"scl/sda/busy/done/byte/nack/rej expected ",
                        "%b %b %b %b %h %b %b, got %b %b %b %b %h %b %b"},
                        want.scl_pull_low, want.sda_pull_low, want.busy, want.done,
                        want.read_byte, want.nack, want.rejected,
                        got.scl_pull_low, got.sda_pull_low, got.busy, got.done,
                        got.read_byte, got.nack, got.rejected));
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        reset_bus_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_ops();
        test_busy_and_unused();
        test_zero_ticks();
        test_extreme_ticks();
        items_sent = 0;
        test_random_traffic();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### sim.f
rtl/i2cm_pkg.sv
rtl/i2c_master_byte_engine.sv
dv/tb.sv
